@@ sv/assert_macros.svh @@
// Assertion macros used by the fragment depth test and blend RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FDTB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define FDTB_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ sv/fdtb_pkg.sv @@
// Package with the types, codes and helper functions of the depth test and blend unit.
package fdtb_pkg;

   // Depth is unsigned fixed point; all ones means 1.0.
   localparam int unsigned DEPTH_BITS   = 16;
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
   localparam int unsigned FRAG_DEPTH_W = 18;
   localparam int unsigned COLOR_W      = 8;
   localparam int unsigned LANES        = 4;
   localparam int unsigned PIXEL_W      = COLOR_W * LANES;
   localparam int unsigned POS_W        = 8;
   localparam int unsigned DIM_W        = 9;
   localparam int unsigned SUM_W        = 16;

   // Register interface.
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam logic        CSR_IDX_FRAME_WIDTH  = 1'b0;
   localparam logic        CSR_IDX_FRAME_HEIGHT = 1'b1;
   localparam logic [DIM_W-1:0] FRAME_DIM_RESET = 9'd256;

   // Request modes.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE    = 2'd1;
   localparam logic [1:0] STATUS_DEPTH_FAIL = 2'd2;

   localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'd255;
   localparam logic [SUM_W-1:0]   ROUND_HALF   = 16'd127;

   // One fragment or read request as held inside the unit.
   typedef struct packed {
      logic                           mode;
      logic [POS_W-1:0]               pos_x;
      logic [POS_W-1:0]               pos_y;
      logic signed [FRAG_DEPTH_W-1:0] frag_depth;
      logic [COLOR_W-1:0]             src_red;
      logic [COLOR_W-1:0]             src_green;
      logic [COLOR_W-1:0]             src_blue;
      logic [COLOR_W-1:0]             src_alpha;
      logic                           test_depth;
      logic                           write_depth;
      logic                           blend_on;
   } frag_type;

   // Division by 255 for values below 65280, exact for the blend range.
   function automatic logic [COLOR_W-1:0] div255(input logic [SUM_W-1:0] value);
      logic [SUM_W-1:0] t;
      t = value + {8'd0, value[SUM_W-1:8]} + 16'd1;
      return t[SUM_W-1:8];
   endfunction

endpackage

@@ sv/fdtb_chan_if.sv @@
// Request and result channel interfaces of the depth test and blend unit.
interface fdtb_req_if;
   logic                                            valid;
   logic                                            ready;
   logic                                            mode;
   logic [fdtb_pkg::POS_W-1:0]                      pos_x;
   logic [fdtb_pkg::POS_W-1:0]                      pos_y;
   logic signed [fdtb_pkg::FRAG_DEPTH_W-1:0]        frag_depth;
   logic [fdtb_pkg::COLOR_W-1:0]                    src_red;
   logic [fdtb_pkg::COLOR_W-1:0]                    src_green;
   logic [fdtb_pkg::COLOR_W-1:0]                    src_blue;
   logic [fdtb_pkg::COLOR_W-1:0]                    src_alpha;
   logic                                            test_depth;
   logic                                            write_depth;
   logic                                            blend_on;

   modport source (
      output valid, mode, pos_x, pos_y, frag_depth, src_red, src_green, src_blue,
             src_alpha, test_depth, write_depth, blend_on,
      input  ready
   );
   modport sink (
      input  valid, mode, pos_x, pos_y, frag_depth, src_red, src_green, src_blue,
             src_alpha, test_depth, write_depth, blend_on,
      output ready
   );
endinterface

interface fdtb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic [fdtb_pkg::COLOR_W-1:0]        out_red;
   logic [fdtb_pkg::COLOR_W-1:0]        out_green;
   logic [fdtb_pkg::COLOR_W-1:0]        out_blue;
   logic [fdtb_pkg::COLOR_W-1:0]        out_alpha;
   logic [fdtb_pkg::DEPTH_BITS-1:0]     out_depth;

   modport source (
      output valid, status, out_red, out_green, out_blue, out_alpha, out_depth,
      input  ready
   );
   modport sink (
      input  valid, status, out_red, out_green, out_blue, out_alpha, out_depth,
      output ready
   );
endinterface

@@ sv/fragment_depth_test_blend.sv @@
// Top level of the fragment depth test and premultiplied blend unit.
//
// The request channel carries write fragments and pixel reads; the result channel returns
// one result per request: a status and, inside the frame, the pixel as stored after the
// operation. The frame size registers sit behind an APB-style port and are to be written
// only while the unit is idle, which the block itself does not enforce. For each request the
// pixel is read from the color and depth stores, the depth test and the blend products are
// formed, then the stores are written back and the result is loaded into the output
// register. A new request is not taken until the current one has been written back, as the
// unit runs the read, compute and write-back steps of one request at a time. A waiting
// result does not stop the next request from entering; while the receiver stalls, the unit
// holds its current request in the write-back step. After reset the unit sweeps the stores
// once, one pixel per cycle, setting color to zero and depth to 1.0; no request is taken
// until it ends. Register writes are accepted during the sweep.
`include "assert_macros.svh"

module fragment_depth_test_blend #(
   parameter int unsigned MAX_WIDTH  = 256,
   parameter int unsigned MAX_HEIGHT = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   fdtb_req_if.sink                            req_chan,
   fdtb_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fdtb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [fdtb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [fdtb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned PIXELS = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned ADDR_W = $clog2(PIXELS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_CALC  = 2'd3;

   localparam int unsigned CW = fdtb_pkg::COLOR_W;
   localparam int unsigned DB = fdtb_pkg::DEPTH_BITS;
   localparam int unsigned FW = fdtb_pkg::FRAG_DEPTH_W;

   // Pixel stores.
   logic [fdtb_pkg::PIXEL_W-1:0] color_mem [PIXELS];
   logic [DB-1:0]                depth_mem [PIXELS];

   logic [1:0]                   state_ff, state_in;
   logic [ADDR_W-1:0]            clr_ff, clr_in;
   logic [fdtb_pkg::DIM_W-1:0]   frame_width_ff, frame_width_in;
   logic [fdtb_pkg::DIM_W-1:0]   frame_height_ff, frame_height_in;

   fdtb_pkg::frag_type           item_ff, req_item;
   logic [ADDR_W-1:0]            addr_ff, req_addr;
   logic                         outside_ff, req_outside;
   logic                         req_fire, csr_write;

   logic [fdtb_pkg::PIXEL_W-1:0] color_rd_ff;
   logic [DB-1:0]                depth_rd_ff;

   // Compute stage registers.
   logic [fdtb_pkg::SUM_W-1:0]   sum_ff [fdtb_pkg::LANES];
   logic [fdtb_pkg::SUM_W-1:0]   sum_in [fdtb_pkg::LANES];
   logic                         fail_ff, fail_in;
   logic                         use_blend_ff, use_blend_in;
   logic [DB-1:0]                clamp_ff, clamp_in;

   // Write-back signals.
   logic                         out_free;
   logic                         color_we, depth_we;
   logic [ADDR_W-1:0]            wr_addr;
   logic [fdtb_pkg::PIXEL_W-1:0] wr_color;
   logic [DB-1:0]                wr_depth;
   logic [fdtb_pkg::PIXEL_W-1:0] new_color;
   logic [DB-1:0]                new_depth;
   logic [CW-1:0]                blend_lane [fdtb_pkg::LANES];

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;
   logic [fdtb_pkg::PIXEL_W-1:0] rsp_color_ff, rsp_color_in;
   logic [DB-1:0]                rsp_depth_ff, rsp_depth_in;

   // Request decode: frame bounds and pixel address.
   always_comb begin
      req_item.mode        = req_chan.mode;
      req_item.pos_x       = req_chan.pos_x;
      req_item.pos_y       = req_chan.pos_y;
      req_item.frag_depth  = req_chan.frag_depth;
      req_item.src_red     = req_chan.src_red;
      req_item.src_green   = req_chan.src_green;
      req_item.src_blue    = req_chan.src_blue;
      req_item.src_alpha   = req_chan.src_alpha;
      req_item.test_depth  = req_chan.test_depth;
      req_item.write_depth = req_chan.write_depth;
      req_item.blend_on    = req_chan.blend_on;
      req_outside = (32'(req_chan.pos_x) >= 32'(frame_width_ff))
                 || (32'(req_chan.pos_x) >= MAX_WIDTH)
                 || (32'(req_chan.pos_y) >= 32'(frame_height_ff))
                 || (32'(req_chan.pos_y) >= MAX_HEIGHT);
      req_addr = ADDR_W'(32'(req_chan.pos_y) * MAX_WIDTH + 32'(req_chan.pos_x));
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Depth test, clamping and blend products of the read pixel.
   always_comb begin
      logic                 neg, over;
      logic [CW-1:0]        alpha, inv_alpha;
      logic [CW-1:0]        src_lane [fdtb_pkg::LANES];
      neg       = item_ff.frag_depth[FW-1];
      over      = !neg && (|item_ff.frag_depth[FW-2:DB]);
      alpha     = item_ff.src_alpha;
      inv_alpha = fdtb_pkg::ALPHA_OPAQUE - alpha;
      src_lane[0] = item_ff.src_red;
      src_lane[1] = item_ff.src_green;
      src_lane[2] = item_ff.src_blue;
      src_lane[3] = '0;
      fail_in = item_ff.test_depth
             && (neg || over || (item_ff.frag_depth[DB-1:0] >= depth_rd_ff));
      if (neg) begin
         clamp_in = '0;
      end else if (over) begin
         clamp_in = fdtb_pkg::DEPTH_MAX;
      end else begin
         clamp_in = item_ff.frag_depth[DB-1:0];
      end
      use_blend_in = item_ff.blend_on && (alpha != fdtb_pkg::ALPHA_OPAQUE);
      // The alpha lane has no source term; its source alpha is added after the division.
      for (int i = 0; i < int'(fdtb_pkg::LANES); i++) begin
         sum_in[i] = fdtb_pkg::SUM_W'(src_lane[i]) * fdtb_pkg::SUM_W'(alpha)
                   + fdtb_pkg::SUM_W'(color_rd_ff[i*CW +: CW])
                     * fdtb_pkg::SUM_W'(inv_alpha)
                   + fdtb_pkg::ROUND_HALF;
      end
   end

   // Blend division, new pixel and result selection.
   always_comb begin
      for (int i = 0; i < int'(fdtb_pkg::LANES); i++) begin
         blend_lane[i] = fdtb_pkg::div255(sum_ff[i]);
      end
      if (use_blend_ff) begin
         new_color = {item_ff.src_alpha + blend_lane[3], blend_lane[2], blend_lane[1],
                      blend_lane[0]};
      end else begin
         new_color = {item_ff.src_alpha, item_ff.src_blue, item_ff.src_green,
                      item_ff.src_red};
      end
      new_depth = item_ff.write_depth ? clamp_ff : depth_rd_ff;
      if (outside_ff) begin
         rsp_status_in = fdtb_pkg::STATUS_OUTSIDE;
         rsp_color_in  = '0;
         rsp_depth_in  = '0;
      end else if (item_ff.mode == fdtb_pkg::MODE_READ) begin
         rsp_status_in = fdtb_pkg::STATUS_OK;
         rsp_color_in  = color_rd_ff;
         rsp_depth_in  = depth_rd_ff;
      end else if (fail_ff) begin
         rsp_status_in = fdtb_pkg::STATUS_DEPTH_FAIL;
         rsp_color_in  = color_rd_ff;
         rsp_depth_in  = depth_rd_ff;
      end else begin
         rsp_status_in = fdtb_pkg::STATUS_OK;
         rsp_color_in  = new_color;
         rsp_depth_in  = new_depth;
      end
   end

   // Sequencer: clearing sweep, then read, compute and write back for each request.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      color_we     = 1'b0;
      depth_we     = 1'b0;
      wr_addr      = addr_ff;
      wr_color     = new_color;
      wr_depth     = clamp_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            color_we = 1'b1;
            depth_we = 1'b1;
            wr_addr  = clr_ff;
            wr_color = '0;
            wr_depth = fdtb_pkg::DEPTH_MAX;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (!outside_ff && item_ff.mode == fdtb_pkg::MODE_WRITE && !fail_ff) begin
                  color_we = 1'b1;
                  depth_we = item_ff.write_depth;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Register port decode.
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write) begin
         if (csr_paddr[2] == fdtb_pkg::CSR_IDX_FRAME_HEIGHT) begin
            frame_height_in = csr_pwdata[fdtb_pkg::DIM_W-1:0];
         end else begin
            frame_width_in  = csr_pwdata[fdtb_pkg::DIM_W-1:0];
         end
      end
      if (csr_paddr[2] == fdtb_pkg::CSR_IDX_FRAME_HEIGHT) begin
         csr_prdata = fdtb_pkg::CSR_DATA_W'(frame_height_ff);
      end else begin
         csr_prdata = fdtb_pkg::CSR_DATA_W'(frame_width_ff);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         frame_width_ff  <= fdtb_pkg::FRAME_DIM_RESET;
         frame_height_ff <= fdtb_pkg::FRAME_DIM_RESET;
      end else begin
         state_ff        <= state_in;
         clr_ff          <= clr_in;
         rsp_valid_ff    <= rsp_valid_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff    <= req_item;
         addr_ff    <= req_addr;
         outside_ff <= req_outside;
      end
      if (state_ff == ST_READ) begin
         for (int i = 0; i < int'(fdtb_pkg::LANES); i++) begin
            sum_ff[i] <= sum_in[i];
         end
         fail_ff      <= fail_in;
         use_blend_ff <= use_blend_in;
         clamp_ff     <= clamp_in;
      end
      if (state_ff == ST_CALC && out_free) begin
         rsp_status_ff <= rsp_status_in;
         rsp_color_ff  <= rsp_color_in;
         rsp_depth_ff  <= rsp_depth_in;
      end
   end

   // Color and depth stores: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (color_we) begin
         color_mem[wr_addr] <= wr_color;
      end
      if (req_fire) begin
         color_rd_ff <= color_mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (depth_we) begin
         depth_mem[wr_addr] <= wr_depth;
      end
      if (req_fire) begin
         depth_rd_ff <= depth_mem[req_addr];
      end
   end

   // Result channel.
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.out_red   = rsp_color_ff[0*CW +: CW];
   assign rsp_chan.out_green = rsp_color_ff[1*CW +: CW];
   assign rsp_chan.out_blue  = rsp_color_ff[2*CW +: CW];
   assign rsp_chan.out_alpha = rsp_color_ff[3*CW +: CW];
   assign rsp_chan.out_depth = rsp_depth_ff;

   // An accepted request passes through ST_READ and then reaches ST_CALC, the write-back step.
   `FDTB_ASSERT(a_seq_order, clock, reset,
      req_fire |=> (state_ff == ST_READ) ##1 (state_ff == ST_CALC),
      "request did not proceed through read and compute")
   // The stores are never written for reads, frame misses or failed depth tests.
   `FDTB_ASSERT_NEVER(a_no_bad_write, clock, reset,
      (state_ff == ST_CALC) && color_we
         && (outside_ff || item_ff.mode == fdtb_pkg::MODE_READ || fail_ff),
      "store written for a request that must leave it unchanged")
   // A frame miss reports an empty pixel.
   `FDTB_ASSERT(a_outside_zero, clock, reset,
      (rsp_valid_ff && rsp_status_ff == fdtb_pkg::STATUS_OUTSIDE)
         |-> (rsp_color_ff == '0 && rsp_depth_ff == '0),
      "frame miss result carries pixel data")
   // A result is loaded only when the output register is free.
   `FDTB_ASSERT(a_no_overwrite, clock, reset,
      (rsp_valid_ff && !rsp_chan.ready) |=> rsp_valid_ff && $stable(rsp_status_ff),
      "pending result overwritten")

endmodule
